@@ rtl/core/srlm_pkg.sv @@
// ----------------------------------------------------------------------------
// srlm_pkg: shared types and constants
// Element format, command codes, register indexes and the control bundle that
// the top level broadcasts to every matcher cell.
// ----------------------------------------------------------------------------
package srlm_pkg;

    localparam int MAX_ELEMENTS_DEFAULT = 32;

    localparam int CMD_W       = 2;
    localparam int INDEX_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_TEXT = 2'd1,
        CMD_EOL  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_ANCHOR_START   = 2'd1,
        REG_ANCHOR_END     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              any;
        logic              star;
        logic [CHAR_W-1:0] ch;
    } elem_t;

    typedef struct packed {
        logic              text_step;
        logic              line_clear;
        logic [CHAR_W-1:0] text_char;
        elem_t             elem;
    } cell_ctrl_t;

endpackage

@@ rtl/core/srlm_in_if.sv @@
// ----------------------------------------------------------------------------
// srlm_in_if: command channel
// Valid/ready channel carrying load, text and end-of-line commands.
// ----------------------------------------------------------------------------
interface srlm_in_if
    import srlm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [INDEX_W-1:0]    elem_index;
    logic [CHAR_W-1:0]     elem_char;
    logic                  elem_star;
    logic                  elem_any;
    logic [CHAR_W-1:0]     text_char;

    modport source (output valid, cmd, elem_index, elem_char, elem_star, elem_any,
                    text_char, input ready);
    modport sink   (input valid, cmd, elem_index, elem_char, elem_star, elem_any,
                    text_char, output ready);
endinterface

@@ rtl/core/srlm_out_if.sv @@
// ----------------------------------------------------------------------------
// srlm_out_if: result channel
// Valid/ready channel carrying the per-line match verdict.
// ----------------------------------------------------------------------------
interface srlm_out_if
    import srlm_pkg::*;
();
    logic valid;
    logic ready;
    logic line_matched;

    modport source (output valid, line_matched, input ready);
    modport sink   (input valid, line_matched, output ready);
endinterface

@@ rtl/core/srlm_cell.sv @@
// ----------------------------------------------------------------------------
// srlm_cell: one pattern position of the matcher
// Holds one pattern element and the active bit of the prefix ending before
// it, forms the star closure from its left neighbour and hands the advance
// bit to its right neighbour on every text beat.
// ----------------------------------------------------------------------------
module srlm_cell
    import srlm_pkg::*;
#(
    parameter bit IS_FIRST = 1'b0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       load_sel,
    input  logic       in_use,
    input  logic       carry_in,
    input  logic       adv_in,
    output logic       closed_out,
    output logic       carry_out,
    output logic       adv_out
);

    elem_t elem_reg;
    logic  active_reg;
    logic  active_next;
    logic  take;

    // The prefix is live if it was reached directly or by skipping a starred
    // element on the left.
    assign closed_out = active_reg | carry_in;
    assign carry_out  = closed_out & in_use & elem_reg.star;
    assign take       = closed_out & in_use &
                        (elem_reg.any | (elem_reg.ch == ctrl.text_char));
    assign adv_out    = take & ~elem_reg.star;

    always_comb
    begin
        active_next = active_reg;
        if (ctrl.line_clear)
        begin
            active_next = IS_FIRST;
        end
        else if (ctrl.text_step)
        begin
            active_next = (take & elem_reg.star) | adv_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= IS_FIRST;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_sel)
        begin
            elem_reg <= ctrl.elem;
        end
    end

endmodule

@@ rtl/core/simple_regex_line_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// simple_regex_line_matcher_unit: streaming line matcher for small regexes
// Row of pattern cells forming a parallel NFA, with found flag and result
// register.
// ----------------------------------------------------------------------------
// The block takes one command beat per clock cycle, every cycle, as long as
// the result register is empty or being drained in the same cycle. Load and
// text beats give no result; an end-of-line beat puts its verdict into the
// result register at the next edge. The clock period is set by the star
// closure rippling through the row of MAX_ELEMENTS cells and the final
// selection of the prefix at the pattern length.
module simple_regex_line_matcher_unit
    import srlm_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    srlm_in_if.sink                in_ch,
    srlm_out_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);

    logic [CFG_DATA_W-1:0] pattern_length_reg;
    logic                  anchor_start_reg;
    logic                  anchor_end_reg;
    logic                  found_reg;
    logic                  found_next;
    logic                  active_end_reg;
    logic                  active_end_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_matched_reg;
    logic                  out_matched_next;

    logic                  accept;
    logic                  is_load;
    logic                  is_text;
    logic                  is_eol;
    logic [CFG_DATA_W-1:0] len_eff;
    logic [LEN_W-1:0]      len_idx;
    logic                  hit;
    cell_ctrl_t            ctrl;

    logic [MAX_ELEMENTS:0]   carry;
    logic [MAX_ELEMENTS:0]   adv;
    logic [MAX_ELEMENTS:0]   closed_vec;
    logic [MAX_ELEMENTS-1:0] load_sel;
    logic [MAX_ELEMENTS-1:0] in_use;

    assign in_ch.ready = ~out_valid_reg | out_ch.ready;
    assign accept      = in_ch.valid & in_ch.ready;

    always_comb
    begin
        is_load = 1'b0;
        is_text = 1'b0;
        is_eol  = 1'b0;
        unique case (cmd_t'(in_ch.cmd))
            CMD_LOAD: is_load = accept;
            CMD_TEXT: is_text = accept;
            CMD_EOL:  is_eol  = accept;
            default:  ;
        endcase
    end

    assign len_eff = (pattern_length_reg > CFG_DATA_W'(MAX_ELEMENTS)) ?
                     CFG_DATA_W'(MAX_ELEMENTS) : pattern_length_reg;
    assign len_idx = len_eff[LEN_W-1:0];

    assign ctrl.text_step = is_text;
    assign ctrl.line_clear = is_eol;
    assign ctrl.text_char = in_ch.text_char;
    assign ctrl.elem.any  = in_ch.elem_any;
    assign ctrl.elem.star = in_ch.elem_star;
    assign ctrl.elem.ch   = in_ch.elem_char;

    assign carry[0] = 1'b0;
    // Without the start anchor a fresh attempt begins at every position.
    assign adv[0]   = ~anchor_start_reg;

    for (genvar g = 0; g < MAX_ELEMENTS; g++)
    begin : g_cell
        assign load_sel[g] = is_load &
                             ({1'b0, in_ch.elem_index} == CFG_DATA_W'(g));
        assign in_use[g]   = len_eff > CFG_DATA_W'(g);

        srlm_cell #(
            .IS_FIRST (g == 0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .load_sel   (load_sel[g]),
            .in_use     (in_use[g]),
            .carry_in   (carry[g]),
            .adv_in     (adv[g]),
            .closed_out (closed_vec[g]),
            .carry_out  (carry[g+1]),
            .adv_out    (adv[g+1])
        );
    end

    assign closed_vec[MAX_ELEMENTS] = active_end_reg | carry[MAX_ELEMENTS];
    assign hit = closed_vec[len_idx];

    always_comb
    begin
        found_next       = found_reg;
        active_end_next  = active_end_reg;
        out_valid_next   = out_valid_reg & ~out_ch.ready;
        out_matched_next = out_matched_reg;
        if (is_text)
        begin
            found_next      = found_reg | (~anchor_end_reg & hit);
            active_end_next = adv[MAX_ELEMENTS];
        end
        else if (is_eol)
        begin
            found_next       = 1'b0;
            active_end_next  = 1'b0;
            out_valid_next   = 1'b1;
            out_matched_next = found_reg | hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            anchor_start_reg   <= 1'b0;
            anchor_end_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data;
                REG_ANCHOR_START:   anchor_start_reg   <= cfg_data[0];
                REG_ANCHOR_END:     anchor_end_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            active_end_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            found_reg      <= found_next;
            active_end_reg <= active_end_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_matched_reg <= out_matched_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.line_matched = out_matched_reg;

endmodule

@@ bench/tb_simple_regex_line_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// tb_simple_regex_line_matcher_unit: self-checking bench for the line matcher
// Drives pattern loads, text characters and end-of-line beats into the
// command channel. A prefix-set tracker of the NFA predicts each line verdict,
// and every verdict beat is compared in order with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_simple_regex_line_matcher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import srlm_pkg::*;

    localparam int               MAX_ELEM      = MAX_ELEMENTS_DEFAULT;
    localparam logic [CMD_W-1:0] CMD_SPARE     = 2'd3;
    localparam int               HOLD_CYCLES   = 300;
    localparam int               SETTLE_CYCLES = 4;
    localparam int               MAX_REPORTS   = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    srlm_in_if  in_ch ();
    srlm_out_if out_ch ();

    simple_regex_line_matcher_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Tracker of the matcher: pattern table, active prefixes and found flag.
    elem_t                 nfa_table [MAX_ELEM];
    logic [MAX_ELEM:0]     nfa_active;
    logic                  nfa_found;
    logic [CFG_DATA_W-1:0] cur_length;
    logic                  cur_anchor_start;
    logic                  cur_anchor_end;

    logic              verdict_q [$];
    logic [CHAR_W-1:0] line_chars [$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int beats_sent     = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int used_length();
        return (cur_length > MAX_ELEM) ? MAX_ELEM : int'(cur_length);
    endfunction

    // A prefix that ends just before a star element may also skip that element.
    function automatic logic [MAX_ELEM:0] star_closure(input logic [MAX_ELEM:0] set_in,
                                                       input int n);
        logic [MAX_ELEM:0] set_out;
        set_out = set_in;
        for (int i = 0; i < n; i++)
        begin
            if (set_out[i] && nfa_table[i].star)
                set_out[i + 1] = 1'b1;
        end
        return set_out;
    endfunction

    task automatic track_beat(input logic [CMD_W-1:0] c, input logic [INDEX_W-1:0] idx,
                              input elem_t el, input logic [CHAR_W-1:0] ch);
        int                n;
        logic [MAX_ELEM:0] cur;
        logic [MAX_ELEM:0] nxt;
        n   = used_length();
        cur = star_closure(nfa_active, n);
        if (c == CMD_LOAD)
        begin
            nfa_table[idx] = el;
        end
        else if (c == CMD_TEXT)
        begin
            if (!cur_anchor_end && cur[n])
                nfa_found = 1'b1;
            nxt = '0;
            for (int i = 0; i < n; i++)
            begin
                if (cur[i] && (nfa_table[i].any || nfa_table[i].ch == ch))
                begin
                    if (nfa_table[i].star)
                        nxt[i] = 1'b1;
                    else
                        nxt[i + 1] = 1'b1;
                end
            end
            if (!cur_anchor_start)
                nxt[0] = 1'b1;
            nfa_active = nxt;
        end
        else if (c == CMD_EOL)
        begin
            verdict_q.push_back(nfa_found || cur[n]);
            nfa_active = 1;
            nfa_found  = 1'b0;
        end
    endtask

    // Called and left at a rising edge; the beat is taken when ready was high
    // through the low half of the clock before that edge.
    task automatic send_beat(input logic [CMD_W-1:0] c, input logic [INDEX_W-1:0] idx,
                             input elem_t el, input logic [CHAR_W-1:0] ch);
        logic taken;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= c;
        in_ch.elem_index <= idx;
        in_ch.elem_char  <= el.ch;
        in_ch.elem_star  <= el.star;
        in_ch.elem_any   <= el.any;
        in_ch.text_char  <= ch;
        do
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        track_beat(c, idx, el, ch);
        if (c != CMD_SPARE)
            beats_sent++;
    endtask

    function automatic elem_t random_elem();
        return elem_t'(10'($urandom));
    endfunction

    function automatic logic [CHAR_W-1:0] random_text_char();
        if ($urandom_range(0, 9) == 0)
            return CHAR_W'($urandom);
        return CHAR_W'(8'h61 + $urandom_range(0, 3));
    endfunction

    // Fields that a command does not use carry random values.
    task automatic load_elem(input logic [INDEX_W-1:0] idx, input logic [CHAR_W-1:0] ch,
                             input logic is_star, input logic is_any);
        send_beat(CMD_LOAD, idx, '{any: is_any, star: is_star, ch: ch}, CHAR_W'($urandom));
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        send_beat(CMD_TEXT, INDEX_W'($urandom), random_elem(), ch);
    endtask

    task automatic end_line();
        send_beat(CMD_EOL, INDEX_W'($urandom), random_elem(), CHAR_W'($urandom));
    endtask

    task automatic send_spare();
        send_beat(CMD_SPARE, INDEX_W'($urandom), random_elem(), CHAR_W'($urandom));
    endtask

    // All three registers in consecutive cycles; the anchors get random upper bits.
    task automatic configure(input logic [CFG_DATA_W-1:0] len, input logic a_start,
                             input logic a_end);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        cur_length = len;
        cfg_index <= REG_ANCHOR_START;
        cfg_data  <= {(CFG_DATA_W-1)'($urandom), a_start};
        @(posedge clk);
        cur_anchor_start = a_start;
        cfg_index <= REG_ANCHOR_END;
        cfg_data  <= {(CFG_DATA_W-1)'($urandom), a_end};
        @(posedge clk);
        cur_anchor_end = a_end;
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Straight after reset the length is zero, so every line matches.
    task automatic test_empty_pattern();
        end_line();
        send_spare();
        send_char(8'h00);
        end_line();
    endtask

    task automatic test_directed_elements();
        load_elem(0, 8'h00, 1'b0, 1'b0);
        load_elem(1, 8'hFF, 1'b1, 1'b0);
        load_elem(2, 8'h41, 1'b0, 1'b1);
        wait_idle();
        configure(3, 1'b0, 1'b0);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'hFF);
        send_char(8'h37);
        end_line();
        send_char(8'h01);
        end_line();
        wait_idle();
        configure(3, 1'b1, 1'b0);
        send_char(8'h05);
        send_char(8'h00);
        send_char(8'h12);
        end_line();
        wait_idle();
        configure(3, 1'b0, 1'b1);
        send_char(8'h00);
        send_char(8'h22);
        end_line();
        // The last element turns into a star in the middle of a line.
        send_char(8'h00);
        load_elem(2, 8'h7E, 1'b1, 1'b0);
        end_line();
        wait_idle();
    endtask

    // The receiver holds off while the sender keeps offering lines, so the
    // result register fills and the command channel stalls.
    task automatic test_full_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        wait_idle();
        configure(2, 1'b0, 1'b0);
        load_elem(0, 8'h61, 1'b1, 1'b0);
        load_elem(1, 8'h62, 1'b0, 1'b0);
        hold_left = HOLD_CYCLES;
        repeat (20)
        begin
            send_char(random_text_char());
            end_line();
        end
        wait_idle();
    endtask

    task automatic test_random_lines(input int gap_pct, input int stall_pct, input int count,
                                     input int first_len);
        int    stop_at;
        int    len;
        int    n;
        int    reps;
        bit    first;
        elem_t e;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        stop_at        = beats_sent + count;
        first          = 1'b1;
        while (beats_sent < stop_at)
        begin
            wait_idle();
            if (first)
            begin
                len = first_len;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:       len = 0;
                    1:       len = MAX_ELEM;
                    2:       len = 63;
                    3:       len = $urandom_range(MAX_ELEM + 1, 62);
                    default: len = $urandom_range(1, 6);
                endcase
            end
            first = 1'b0;
            configure(CFG_DATA_W'(len), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            n = used_length();
            for (int i = 0; i < n; i++)
            begin
                load_elem(INDEX_W'(i), random_text_char(), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 6) == 0);
            end
            repeat ($urandom_range(2, 6))
            begin
                line_chars.delete();
                if ($urandom_range(0, 19) == 0)
                begin
                    repeat ($urandom_range(0, 8)) line_chars.push_back(CHAR_W'($urandom));
                end
                else
                begin
                    // Mostly text that spells the pattern out, with junk around it.
                    repeat ($urandom_range(0, 3)) line_chars.push_back(random_text_char());
                    if ($urandom_range(0, 2) != 0)
                    begin
                        for (int i = 0; i < used_length(); i++)
                        begin
                            e    = nfa_table[i];
                            reps = e.star ? $urandom_range(0, 3) : 1;
                            repeat (reps)
                                line_chars.push_back(e.any ? random_text_char() : e.ch);
                        end
                    end
                    else
                    begin
                        repeat ($urandom_range(0, 8)) line_chars.push_back(random_text_char());
                    end
                    repeat ($urandom_range(0, 3)) line_chars.push_back(random_text_char());
                end
                foreach (line_chars[k])
                begin
                    if ($urandom_range(0, 39) == 0)
                        send_spare();
                    if ($urandom_range(0, 59) == 0)
                        load_elem(INDEX_W'($urandom), CHAR_W'($urandom), 1'($urandom),
                                  1'($urandom));
                    send_char(line_chars[k]);
                end
                // Now and then a line runs on into the next one.
                if ($urandom_range(0, 14) != 0)
                    end_line();
            end
        end
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Values are stable through the low half, so a beat seen here is taken
    // at the next rising edge.
    always @(negedge clk)
    begin
        logic want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("verdict beat %0b with no line pending", out_ch.line_matched);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (out_ch.line_matched !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("line verdict mismatch: expected %0b, got %0b",
                                 want, out_ch.line_matched);
                end
            end
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= CMD_LOAD;
        in_ch.elem_index <= '0;
        in_ch.elem_char  <= '0;
        in_ch.elem_star  <= 1'b0;
        in_ch.elem_any   <= 1'b0;
        in_ch.text_char  <= '0;
        foreach (nfa_table[i])
            nfa_table[i] = '0;
        nfa_active       = 1;
        nfa_found        = 1'b0;
        cur_length       = '0;
        cur_anchor_start = 1'b0;
        cur_anchor_end   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pattern();
        test_directed_elements();
        test_full_backpressure();
        test_random_lines(0, 0, 150, MAX_ELEM);
        test_random_lines(65, 0, 150, 63);
        test_random_lines(0, 65, 150, 0);
        test_random_lines(11, 11, 150, 5);
        wait_idle();
        if (error_count == 0 && verdict_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
